>>> hw/rtl/qrs_pkg.sv
// Package for the quadratic root solver: default widths and root count codes.
// No dependencies.
`default_nettype none

package qrs_pkg;

	// default word and fraction widths (Q16.16)
	localparam int WORD_BITS_DEF = 32;
	localparam int FRAC_BITS_DEF = 16;

	// root count codes
	localparam logic [1:0] CNT_NONE  = 2'd0;
	localparam logic [1:0] CNT_ONE   = 2'd1;
	localparam logic [1:0] CNT_TWO   = 2'd2;
	localparam logic [1:0] CNT_DEGEN = 2'd3;

endpackage

`default_nettype wire

>>> hw/rtl/quadratic_root_solver.sv
// Quadratic root solver top level: fully pipelined real roots of a*x^2+b*x+c.
// Depends on qrs_pkg.
`default_nettype none

// Takes one coefficient item (a, b, c, signed fixed point) per cycle unless req_stall is
// high and returns one result item per item, in order. Most of the pipeline depth is in the
// square root, which resolves one root bit per stage over WORD_BITS+1 stages, followed
// by the two dividers, which resolve one quotient bit per stage over WORD_BITS+1 stages.
// The whole pipeline holds while a result is waiting and res_stall is high; req_stall
// follows that condition.
module quadratic_root_solver #(
	parameter int WORD_BITS = qrs_pkg::WORD_BITS_DEF,
	parameter int FRAC_BITS = qrs_pkg::FRAC_BITS_DEF
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic signed [WORD_BITS-1:0] coef_a,
	input  wire logic signed [WORD_BITS-1:0] coef_b,
	input  wire logic signed [WORD_BITS-1:0] coef_c,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [1:0]                       root_count,
	output logic signed [WORD_BITS-1:0]      root_plus,
	output logic signed [WORD_BITS-1:0]      root_minus,
	output logic                             saturated
);

	localparam int W   = WORD_BITS;
	localparam int F   = FRAC_BITS;
	localparam int DW  = 2 * W + 2;   // discriminant
	localparam int SW  = W + 1;       // square root
	localparam int RW  = SW + 3;      // square root remainder
	localparam int NMW = W + 2;       // numerator magnitude
	localparam int NW  = NMW + F;     // scaled numerator
	localparam int QW  = W + 1;       // quotient
	localparam int DVW = W + 1;       // divisor 2|a|
	localparam int CW  = NW + DVW;    // overflow compare

	logic en;

	// whole pipeline advances unless a result is held
	assign en        = !(res_valid && res_stall);
	assign req_stall = !en;

	// split into sign and magnitude
	logic         an_c, bn_c, cn_c;
	logic [W-1:0] am_c, bm_c, cm_c;

	always_comb begin
		an_c = coef_a[W-1];
		bn_c = coef_b[W-1];
		cn_c = coef_c[W-1];
		am_c = an_c ? (~coef_a + 1'b1) : coef_a;
		bm_c = bn_c ? (~coef_b + 1'b1) : coef_b;
		cm_c = cn_c ? (~coef_c + 1'b1) : coef_c;
	end

	// stage 1: magnitudes
	logic         v_s1, an_s1, bn_s1, cn_s1;
	logic [W-1:0] am_s1, bm_s1, cm_s1;

	// stage 2: products
	logic           v_s2, an_s2, bn_s2, opp_s2;
	logic [W-1:0]   am_s2, bm_s2;
	logic [2*W-1:0] b2_s2, ac_s2;

	// stage 3: discriminant and class
	logic          v_s3, an_s3, bn_s3;
	logic [1:0]    cnt_s3;
	logic [W-1:0]  am_s3, bm_s3;
	logic [DW-1:0] d_s3;

	logic [DW-1:0] b2_c, ac4_c, d_c;
	logic [1:0]    cnt_c;

	always_comb begin
		b2_c  = DW'(b2_s2);
		ac4_c = {ac_s2, 2'b00};
		d_c   = '0;
		cnt_c = qrs_pkg::CNT_NONE;
		if (am_s2 == '0) begin
			cnt_c = qrs_pkg::CNT_DEGEN;
		end else if (opp_s2) begin
			d_c   = b2_c + ac4_c;
			cnt_c = qrs_pkg::CNT_TWO;
		end else if (b2_c >= ac4_c) begin
			d_c   = b2_c - ac4_c;
			cnt_c = (d_c == '0) ? qrs_pkg::CNT_ONE : qrs_pkg::CNT_TWO;
		end
	end

	// stage 4: square root, one bit per stage
	logic          sq_v_s4    [SW];
	logic          sq_an_s4   [SW];
	logic          sq_bn_s4   [SW];
	logic [1:0]    sq_cnt_s4  [SW];
	logic [W-1:0]  sq_am_s4   [SW];
	logic [W-1:0]  sq_bm_s4   [SW];
	logic [DW-1:0] sq_rad_s4  [SW];
	logic [RW-1:0] sq_rem_s4  [SW];
	logic [SW-1:0] sq_root_s4 [SW];

	logic [DW-1:0] sq_rad_n  [SW];
	logic [RW-1:0] sq_rem_n  [SW];
	logic [SW-1:0] sq_root_n [SW];

	always_comb begin
		logic [DW-1:0] rad;
		logic [RW-1:0] rem, trial, rin;
		logic [SW-1:0] root;
		for (int j = 0; j < SW; j++) begin
			if (j == 0) begin
				rad  = d_s3;
				rem  = '0;
				root = '0;
			end else begin
				rad  = sq_rad_s4[j-1];
				rem  = sq_rem_s4[j-1];
				root = sq_root_s4[j-1];
			end
			rin   = {rem[RW-3:0], rad[DW-1:DW-2]};
			trial = RW'({root, 2'b01});
			sq_rad_n[j] = rad << 2;
			if (rin >= trial) begin
				sq_rem_n[j]  = rin - trial;
				sq_root_n[j] = {root[SW-2:0], 1'b1};
			end else begin
				sq_rem_n[j]  = rin;
				sq_root_n[j] = {root[SW-2:0], 1'b0};
			end
		end
	end

	// stage 5: numerators -b +/- sqrt(D) in sign and magnitude
	logic           v_s5, negp_s5, negm_s5;
	logic [1:0]     cnt_s5;
	logic [NMW-1:0] nmp_s5, nmm_s5;
	logic [DVW-1:0] dv_s5;

	logic           negp_c, negm_c;
	logic [NMW-1:0] nmp_c, nmm_c, bmx, sx;

	always_comb begin
		bmx = NMW'(sq_bm_s4[SW-1]);
		sx  = NMW'(sq_root_s4[SW-1]);
		// plus: (-b) + S
		if (sq_bn_s4[SW-1]) begin
			negp_c = 1'b0;
			nmp_c  = bmx + sx;
		end else if (bmx >= sx) begin
			negp_c = 1'b1;
			nmp_c  = bmx - sx;
		end else begin
			negp_c = 1'b0;
			nmp_c  = sx - bmx;
		end
		// minus: (-b) - S
		if (!sq_bn_s4[SW-1]) begin
			negm_c = 1'b1;
			nmm_c  = bmx + sx;
		end else if (bmx >= sx) begin
			negm_c = 1'b0;
			nmm_c  = bmx - sx;
		end else begin
			negm_c = 1'b1;
			nmm_c  = sx - bmx;
		end
	end

	// stage 6: scale numerators, catch quotients too wide
	logic           v_s6, negp_s6, negm_s6, ovfp_s6, ovfm_s6;
	logic [1:0]     cnt_s6;
	logic [DVW-1:0] dv_s6;
	logic [DVW:0]   remp_s6, remm_s6;
	logic [QW-1:0]  nlp_s6, nlm_s6;

	logic [NW-1:0] nump_c, numm_c;
	logic [CW-1:0] dlim_c;

	always_comb begin
		nump_c = NW'(nmp_s5) << F;
		numm_c = NW'(nmm_s5) << F;
		dlim_c = CW'(dv_s5) << QW;
	end

	// stage 7: two dividers, one quotient bit per stage
	logic           dp_v_s7    [QW];
	logic           dp_negp_s7 [QW];
	logic           dp_negm_s7 [QW];
	logic           dp_ovfp_s7 [QW];
	logic           dp_ovfm_s7 [QW];
	logic [1:0]     dp_cnt_s7  [QW];
	logic [DVW-1:0] dp_dv_s7   [QW];
	logic [DVW:0]   dp_remp_s7 [QW];
	logic [DVW:0]   dp_remm_s7 [QW];
	logic [QW-1:0]  dp_nlp_s7  [QW];
	logic [QW-1:0]  dp_nlm_s7  [QW];
	logic [QW-1:0]  dp_qp_s7   [QW];
	logic [QW-1:0]  dp_qm_s7   [QW];

	logic [DVW:0]  dp_remp_n [QW];
	logic [DVW:0]  dp_remm_n [QW];
	logic [QW-1:0] dp_qp_n   [QW];
	logic [QW-1:0] dp_qm_n   [QW];

	always_comb begin
		logic [DVW-1:0] dv;
		logic [DVW:0]   rp, rm, tp, tm;
		logic [QW-1:0]  lp, lm, qp, qm;
		for (int j = 0; j < QW; j++) begin
			if (j == 0) begin
				dv = dv_s6;
				rp = remp_s6;
				rm = remm_s6;
				lp = nlp_s6;
				lm = nlm_s6;
				qp = '0;
				qm = '0;
			end else begin
				dv = dp_dv_s7[j-1];
				rp = dp_remp_s7[j-1];
				rm = dp_remm_s7[j-1];
				lp = dp_nlp_s7[j-1];
				lm = dp_nlm_s7[j-1];
				qp = dp_qp_s7[j-1];
				qm = dp_qm_s7[j-1];
			end
			tp = {rp[DVW-1:0], lp[QW-1]};
			tm = {rm[DVW-1:0], lm[QW-1]};
			if (tp >= {1'b0, dv}) begin
				dp_remp_n[j] = tp - {1'b0, dv};
				dp_qp_n[j]   = {qp[QW-2:0], 1'b1};
			end else begin
				dp_remp_n[j] = tp;
				dp_qp_n[j]   = {qp[QW-2:0], 1'b0};
			end
			if (tm >= {1'b0, dv}) begin
				dp_remm_n[j] = tm - {1'b0, dv};
				dp_qm_n[j]   = {qm[QW-2:0], 1'b1};
			end else begin
				dp_remm_n[j] = tm;
				dp_qm_n[j]   = {qm[QW-2:0], 1'b0};
			end
		end
	end

	// final: saturate, apply sign, mask by class
	logic [QW-1:0] limp_c, limm_c, valp_c, valm_c;
	logic          satp_c, satm_c;
	logic [W-1:0]  rp_c, rm_c;

	always_comb begin
		limp_c = dp_negp_s7[QW-1] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - 1'b1);
		limm_c = dp_negm_s7[QW-1] ? (QW'(1) << (W-1)) : ((QW'(1) << (W-1)) - 1'b1);
		satp_c = dp_ovfp_s7[QW-1] || (dp_qp_s7[QW-1] > limp_c);
		satm_c = dp_ovfm_s7[QW-1] || (dp_qm_s7[QW-1] > limm_c);
		valp_c = satp_c ? limp_c : dp_qp_s7[QW-1];
		valm_c = satm_c ? limm_c : dp_qm_s7[QW-1];
		rp_c   = dp_negp_s7[QW-1] ? (~valp_c[W-1:0] + 1'b1) : valp_c[W-1:0];
		rm_c   = dp_negm_s7[QW-1] ? (~valm_c[W-1:0] + 1'b1) : valm_c[W-1:0];
	end

	logic [1:0]   cnt_s8;
	logic [W-1:0] rp_s8, rm_s8;
	logic         sat_s8, v_s8;

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s8 <= 1'b0;
			for (int j = 0; j < SW; j++) sq_v_s4[j] <= 1'b0;
			for (int j = 0; j < QW; j++) dp_v_s7[j] <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			for (int j = 0; j < SW; j++) sq_v_s4[j] <= (j == 0) ? v_s3 : sq_v_s4[j-1];
			v_s5 <= sq_v_s4[SW-1];
			v_s6 <= v_s5;
			for (int j = 0; j < QW; j++) dp_v_s7[j] <= (j == 0) ? v_s6 : dp_v_s7[j-1];
			v_s8 <= dp_v_s7[QW-1];
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			an_s1 <= an_c;
			bn_s1 <= bn_c;
			cn_s1 <= cn_c;
			am_s1 <= am_c;
			bm_s1 <= bm_c;
			cm_s1 <= cm_c;

			an_s2  <= an_s1;
			bn_s2  <= bn_s1;
			opp_s2 <= (an_s1 != cn_s1) && (cm_s1 != '0);
			am_s2  <= am_s1;
			bm_s2  <= bm_s1;
			b2_s2  <= (2*W)'(bm_s1) * (2*W)'(bm_s1);
			ac_s2  <= (2*W)'(am_s1) * (2*W)'(cm_s1);

			an_s3  <= an_s2;
			bn_s3  <= bn_s2;
			cnt_s3 <= cnt_c;
			am_s3  <= am_s2;
			bm_s3  <= bm_s2;
			d_s3   <= d_c;

			for (int j = 0; j < SW; j++) begin
				sq_an_s4[j]   <= (j == 0) ? an_s3  : sq_an_s4[j-1];
				sq_bn_s4[j]   <= (j == 0) ? bn_s3  : sq_bn_s4[j-1];
				sq_cnt_s4[j]  <= (j == 0) ? cnt_s3 : sq_cnt_s4[j-1];
				sq_am_s4[j]   <= (j == 0) ? am_s3  : sq_am_s4[j-1];
				sq_bm_s4[j]   <= (j == 0) ? bm_s3  : sq_bm_s4[j-1];
				sq_rad_s4[j]  <= sq_rad_n[j];
				sq_rem_s4[j]  <= sq_rem_n[j];
				sq_root_s4[j] <= sq_root_n[j];
			end

			cnt_s5  <= sq_cnt_s4[SW-1];
			negp_s5 <= negp_c != sq_an_s4[SW-1];
			negm_s5 <= negm_c != sq_an_s4[SW-1];
			nmp_s5  <= nmp_c;
			nmm_s5  <= nmm_c;
			dv_s5   <= {sq_am_s4[SW-1], 1'b0};

			cnt_s6  <= cnt_s5;
			negp_s6 <= negp_s5;
			negm_s6 <= negm_s5;
			dv_s6   <= dv_s5;
			ovfp_s6 <= CW'(nump_c) >= dlim_c;
			ovfm_s6 <= CW'(numm_c) >= dlim_c;
			remp_s6 <= (DVW+1)'(nump_c >> QW);
			remm_s6 <= (DVW+1)'(numm_c >> QW);
			nlp_s6  <= nump_c[QW-1:0];
			nlm_s6  <= numm_c[QW-1:0];

			for (int j = 0; j < QW; j++) begin
				dp_negp_s7[j] <= (j == 0) ? negp_s6 : dp_negp_s7[j-1];
				dp_negm_s7[j] <= (j == 0) ? negm_s6 : dp_negm_s7[j-1];
				dp_ovfp_s7[j] <= (j == 0) ? ovfp_s6 : dp_ovfp_s7[j-1];
				dp_ovfm_s7[j] <= (j == 0) ? ovfm_s6 : dp_ovfm_s7[j-1];
				dp_cnt_s7[j]  <= (j == 0) ? cnt_s6  : dp_cnt_s7[j-1];
				dp_dv_s7[j]   <= (j == 0) ? dv_s6   : dp_dv_s7[j-1];
				dp_nlp_s7[j]  <= ((j == 0) ? nlp_s6 : dp_nlp_s7[j-1]) << 1;
				dp_nlm_s7[j]  <= ((j == 0) ? nlm_s6 : dp_nlm_s7[j-1]) << 1;
				dp_remp_s7[j] <= dp_remp_n[j];
				dp_remm_s7[j] <= dp_remm_n[j];
				dp_qp_s7[j]   <= dp_qp_n[j];
				dp_qm_s7[j]   <= dp_qm_n[j];
			end

			cnt_s8 <= dp_cnt_s7[QW-1];
			case (dp_cnt_s7[QW-1])
				qrs_pkg::CNT_ONE: begin
					rp_s8  <= rp_c;
					rm_s8  <= '0;
					sat_s8 <= satp_c;
				end
				qrs_pkg::CNT_TWO: begin
					rp_s8  <= rp_c;
					rm_s8  <= rm_c;
					sat_s8 <= satp_c || satm_c;
				end
				default: begin
					rp_s8  <= '0;
					rm_s8  <= '0;
					sat_s8 <= 1'b0;
				end
			endcase
		end
	end

	assign res_valid  = v_s8;
	assign root_count = cnt_s8;
	assign root_plus  = rp_s8;
	assign root_minus = rm_s8;
	assign saturated  = sat_s8;

	// no root and degenerate items carry zero roots
	a_zero_roots: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && (root_count == qrs_pkg::CNT_NONE || root_count == qrs_pkg::CNT_DEGEN)
		|-> root_plus == '0 && root_minus == '0 && !saturated)
		else $error("nonzero root on an item without real roots");

	// a double root reports no second root
	a_double_root: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && root_count == qrs_pkg::CNT_ONE |-> root_minus == '0)
		else $error("second root set on a double root item");

	// a held result keeps the pipeline frozen; checked on the stage 3 and stage 6 valid bits
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> $stable(v_s3) && $stable(v_s6))
		else $error("pipeline moved while result held");

endmodule

`default_nettype wire
